// ----- rtl/cste_pkg.sv -----
// ---------------------------------------------------------------------------
// cste_pkg: shared types and constants of the cubic spline table evaluator
// Knot record, search word travelling along the cell chain, default sizes.
// ---------------------------------------------------------------------------
package cste_pkg;

    localparam int DEF_MAX_KNOTS = 64;
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 7;
    localparam int DATA_W        = 32;

    localparam logic [CNT_W-1:0] KNOT_COUNT_RESET = 7'd2;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] c;
    } knot_t;

    // search word: query, outcome and the captured segment end points
    typedef struct packed {
        logic                     valid;
        logic                     found;
        logic                     direct;  // result is k0.y as it stands
        logic signed [DATA_W-1:0] qx;
        knot_t                    k0;
        knot_t                    k1;
    } token_t;

endpackage

// ----- rtl/cste_cell.sv -----
// ---------------------------------------------------------------------------
// cste_cell: one knot of the table
// Holds one knot and tests the passing search word against it.
// ---------------------------------------------------------------------------
module cste_cell
    import cste_pkg::*;
#(
    parameter int K  = 0,
    parameter int IW = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  knot_t            wr_knot,
    input  knot_t            prev_knot,
    input  logic [IW-1:0]    n_last,
    input  token_t           tok_in,
    output knot_t            knot_out,
    output token_t           tok_out
);

    knot_t  knot_reg;
    token_t tok_reg;
    token_t tok_next;
    logic   is_last;

    // write own knot on a matching load
    always_ff @(posedge aclk) begin
        if (wr_en && (32'(wr_idx) == K)) begin
            knot_reg <= wr_knot;
        end
    end

    assign is_last = (n_last == IW'(K));

    // test the word against this knot, capture the segment once found
    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.found) begin
            if (K == 0) begin
                if (tok_in.qx <= knot_reg.x) begin
                    tok_next.found  = 1'b1;
                    tok_next.direct = 1'b1;
                    tok_next.k0     = knot_reg;
                end
            end else if (is_last || (knot_reg.x >= tok_in.qx)) begin
                tok_next.found = 1'b1;
                if ((is_last && (tok_in.qx >= knot_reg.x)) || (knot_reg.x == tok_in.qx)) begin
                    tok_next.direct = 1'b1;
                    tok_next.k0     = knot_reg;
                end else begin
                    tok_next.direct = 1'b0;
                    tok_next.k0     = prev_knot;
                    tok_next.k1     = knot_reg;
                end
            end
        end
    end

    // hand the word on to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg.found  <= tok_next.found;
        tok_reg.direct <= tok_next.direct;
        tok_reg.qx     <= tok_next.qx;
        tok_reg.k0     <= tok_next.k0;
        tok_reg.k1     <= tok_next.k1;
    end

    assign knot_out = knot_reg;
    assign tok_out  = tok_reg;

endmodule

// ----- rtl/cste_eval.sv -----
// ---------------------------------------------------------------------------
// cste_eval: segment cubic evaluation
// Serial division for the segment fraction, h*h/6 by reciprocal multiply,
// then a short sequence of multiplies, one pair per cycle, and a saturating sum.
// ---------------------------------------------------------------------------
module cste_eval
    import cste_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  token_t                   seg,
    output logic                     done,
    output logic signed [DATA_W-1:0] result
);

    typedef enum logic [8:0] {
        E_IDLE = 9'b000000001,
        E_HH   = 9'b000000010,
        E_DIV  = 9'b000000100,
        E_M1   = 9'b000001000,
        E_M2   = 9'b000010000,
        E_M3   = 9'b000100000,
        E_M4   = 9'b001000000,
        E_M5   = 9'b010000000,
        E_FIN  = 9'b100000000
    } est_t;

    localparam logic [4:0] DIV_LAST = 5'd31;
    localparam logic [4:0] B_STEPS  = 5'd31;
    localparam logic [31:0] RECIP6  = 32'hAAAA_AAAB;
    localparam logic signed [63:0] HALF_Q31 = 64'sd1073741824;
    localparam logic signed [64:0] SAT_MAX  = 65'sd2147483647;
    localparam logic signed [64:0] SAT_MIN  = -65'sd2147483648;

    est_t state_reg, state_next;
    logic done_reg, done_next;
    logic [4:0] cnt_reg, cnt_next;

    logic signed [31:0] y0_reg, y1_reg, c0_reg, c1_reg;
    logic [31:0] h_reg, dx_reg;
    logic [32:0] brem_reg, brem_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] u_reg, u_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] pa_reg, pa_next, pb_reg, pb_next;
    logic signed [63:0] ta_reg, ta_next, tb_reg, tb_next;
    logic signed [63:0] la_reg, la_next, lb_reg, lb_next;
    logic signed [63:0] m_reg, m_next, lin_reg, lin_next;
    logic [63:0] pq1_reg, pq1_next, pq2_reg, pq2_next;
    logic signed [31:0] result_reg, result_next;

    logic [31:0] a_val, mag;
    logic [32:0] bsh;
    logic [63:0] hr_prod;
    logic [31:0] v_full;
    logic [2:0]  v_low;
    logic [2:0]  vsq6;
    logic [63:0] uu, uv;
    logic signed [33:0] ka, kb;
    logic [63:0] p_sum;
    logic signed [64:0] t_val, s_val;

    assign a_val   = 32'h8000_0000 - b_reg;
    assign mag     = m_reg[63] ? 32'(-m_reg) : m_reg[31:0];
    assign ka      = $signed({2'b00, pa_reg[62:31]}) - $signed({2'b00, a_val});
    assign kb      = $signed({2'b00, pb_reg[62:31]}) - $signed({2'b00, b_reg});
    assign hr_prod = h_reg * RECIP6;

    always_comb begin
        // one step of the fraction division, one bit a cycle
        bsh = {brem_reg[31:0], 1'b0};
        // split h as 6u + v, so h*h/6 = 6u*u + 2u*v + v*v/6
        v_full = h_reg - {u_reg[29:0], 2'b00} - {u_reg[30:0], 1'b0};
        v_low  = v_full[2:0];
        uu     = u_reg * u_reg;
        uv     = u_reg * {29'd0, v_low};
        case (v_low)
            3'd3:    vsq6 = 3'd1;
            3'd4:    vsq6 = 3'd2;
            3'd5:    vsq6 = 3'd4;
            default: vsq6 = 3'd0;
        endcase
        // final sum of linear part and curvature term
        p_sum = pq1_reg + (pq2_reg >> 32);
        t_val = m_reg[63] ? -$signed({1'b0, p_sum}) : $signed({1'b0, p_sum});
        s_val = {lin_reg[63], lin_reg} + t_val;
    end

    always_comb begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        brem_next   = brem_reg;
        b_next      = b_reg;
        u_next      = u_reg;
        q_next      = q_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        ta_next     = ta_reg;
        tb_next     = tb_reg;
        la_next     = la_reg;
        lb_next     = lb_reg;
        m_next      = m_reg;
        lin_next    = lin_reg;
        pq1_next    = pq1_reg;
        pq2_next    = pq2_reg;
        result_next = result_reg;
        case (state_reg)
            E_IDLE: begin
                if (start) begin
                    state_next = E_HH;
                end
            end
            E_HH: begin
                u_next     = {2'b00, hr_prod[63:34]};
                q_next     = '0;
                brem_next  = {1'b0, dx_reg};
                b_next     = '0;
                cnt_next   = '0;
                state_next = E_DIV;
            end
            E_DIV: begin
                if (cnt_reg == 5'd0) begin
                    q_next = {uu[61:0], 2'b00} + {uu[62:0], 1'b0} + {uv[62:0], 1'b0}
                             + {61'd0, vsq6};
                end
                if (cnt_reg < B_STEPS) begin
                    if (bsh >= {1'b0, h_reg}) begin
                        brem_next = bsh - {1'b0, h_reg};
                        b_next    = {b_reg[30:0], 1'b1};
                    end else begin
                        brem_next = bsh;
                        b_next    = {b_reg[30:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = E_M1;
                end
            end
            E_M1: begin
                pa_next    = a_val * a_val;
                pb_next    = b_reg * b_reg;
                state_next = E_M2;
            end
            E_M2: begin
                pa_next    = pa_reg[62:31] * a_val;
                pb_next    = pb_reg[62:31] * b_reg;
                state_next = E_M3;
            end
            E_M3: begin
                ta_next    = ka * c0_reg;
                tb_next    = kb * c1_reg;
                state_next = E_M4;
            end
            E_M4: begin
                m_next     = (ta_reg + tb_reg + HALF_Q31) >>> 31;
                la_next    = $signed({1'b0, a_val}) * y0_reg;
                lb_next    = $signed({1'b0, b_reg}) * y1_reg;
                state_next = E_M5;
            end
            E_M5: begin
                lin_next   = (la_reg + lb_reg + HALF_Q31) >>> 31;
                pq1_next   = mag * q_reg[63:32];
                pq2_next   = mag * q_reg[31:0];
                state_next = E_FIN;
            end
            E_FIN: begin
                if (s_val > SAT_MAX) begin
                    result_next = SAT_MAX[31:0];
                end else if (s_val < SAT_MIN) begin
                    result_next = SAT_MIN[31:0];
                end else begin
                    result_next = s_val[31:0];
                end
                done_next  = 1'b1;
                state_next = E_IDLE;
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // capture the segment at start, advance the datapath
    always_ff @(posedge aclk) begin
        if (start && (state_reg == E_IDLE)) begin
            y0_reg <= seg.k0.y;
            y1_reg <= seg.k1.y;
            c0_reg <= seg.k0.c;
            c1_reg <= seg.k1.c;
            h_reg  <= seg.k1.x - seg.k0.x;
            dx_reg <= seg.qx - seg.k0.x;
        end
        cnt_reg    <= cnt_next;
        brem_reg   <= brem_next;
        b_reg      <= b_next;
        u_reg      <= u_next;
        q_reg      <= q_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        la_reg     <= la_next;
        lb_reg     <= lb_next;
        m_reg      <= m_next;
        lin_reg    <= lin_next;
        pq1_reg    <= pq1_next;
        pq2_reg    <= pq2_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/cubic_spline_table_eval.sv -----
// ---------------------------------------------------------------------------
// cubic_spline_table_eval: cubic spline evaluation over a loaded knot table
// Chain of knot cells for the segment search, then a serial evaluator.
// ---------------------------------------------------------------------------
// Use: knots are loaded one word at a time on the s_ channel (operation 0,
// knot_index, knot_x/y/curvature); a load gives no result. A query word
// (operation 1, query_x) gives one m_value word.
// cfg_wr_en/cfg_wr_data set the number of knots in use; write it only
// while the block is idle.
// A query word walks the chain of MAX_KNOTS cells, one cell a cycle.
// Queries that end on a knot or outside the table end there; a segment
// query then goes through the evaluator: the serial fraction division,
// then the multiply sequence. One query is in flight at a time;
// s_ready is high only while no query is in flight.
// The result sits in an output register; while the receiver stalls, new
// loads and a further query are still taken, and that query's result waits
// in a holding register until the output register is free.
// Reset clears control state and sets the knot count to 2; knot contents
// are undefined until loaded.
// ---------------------------------------------------------------------------
module cubic_spline_table_eval
    import cste_pkg::*;
#(
    parameter int MAX_KNOTS = DEF_MAX_KNOTS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic [IDX_W-1:0]         s_knot_index,
    input  logic signed [DATA_W-1:0] s_knot_x,
    input  logic signed [DATA_W-1:0] s_knot_y,
    input  logic signed [DATA_W-1:0] s_knot_curvature,
    input  logic signed [DATA_W-1:0] s_query_x,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_value,
    input  logic                     cfg_wr_en,
    input  logic [CNT_W-1:0]         cfg_wr_data
);

    localparam int IW = $clog2(MAX_KNOTS);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_EVAL   = 4'b0100,
        ST_OUT    = 4'b1000
    } st_t;

    st_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_value_reg, m_value_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic [31:0] n_ext;
    logic [IW-1:0] n_last;
    logic accept, out_free, eval_start, eval_done;
    logic signed [DATA_W-1:0] eval_result;
    knot_t  wr_knot;
    token_t tok [0:MAX_KNOTS];
    knot_t  kn  [0:MAX_KNOTS-1];

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // knot count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= KNOT_COUNT_RESET;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    // clamp the knot count and take the index of the last knot in use
    always_comb begin
        n_ext = 32'(count_reg);
        if (n_ext < 32'd2) begin
            n_ext = 32'd1;
        end else if (n_ext > 32'(MAX_KNOTS)) begin
            n_ext = 32'(MAX_KNOTS - 1);
        end else begin
            n_ext = n_ext - 32'd1;
        end
    end
    assign n_last = n_ext[IW-1:0];

    assign wr_knot = '{x: s_knot_x, y: s_knot_y, c: s_knot_curvature};

    // inject a query word at the head of the chain
    always_comb begin
        tok[0]        = '0;
        tok[0].valid  = accept && (s_operation == OP_QUERY);
        tok[0].qx     = s_query_x;
    end

    genvar k;
    generate
        for (k = 0; k < MAX_KNOTS; k++) begin : g_cell
            cste_cell #(
                .K  (k),
                .IW (IW)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .wr_en     (accept && (s_operation == OP_LOAD)),
                .wr_idx    (s_knot_index),
                .wr_knot   (wr_knot),
                .prev_knot (kn[(k == 0) ? 0 : k - 1]),
                .n_last    (n_last),
                .tok_in    (tok[k]),
                .knot_out  (kn[k]),
                .tok_out   (tok[k+1])
            );
        end
    endgenerate

    assign eval_start = (state_reg == ST_SEARCH) && tok[MAX_KNOTS].valid
                        && !tok[MAX_KNOTS].direct;

    cste_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (eval_start),
        .seg     (tok[MAX_KNOTS]),
        .done    (eval_done),
        .result  (eval_result)
    );

    // sequence one query: search, evaluate, hand to the output register
    always_comb begin
        state_next   = state_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_operation == OP_QUERY)) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (tok[MAX_KNOTS].valid) begin
                    if (tok[MAX_KNOTS].direct) begin
                        res_next   = tok[MAX_KNOTS].k0.y;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                if (eval_done) begin
                    res_next   = eval_result;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg     <= res_next;
        m_value_reg <= m_value_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

endmodule
